### hw/rtl/sfcrc_pkg.sv
// Shared types, codes and constants of the sync framed CRC-8 receiver.
`timescale 1ns / 1ps

package sfcrc_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 1'd1;

	localparam logic [7:0] FIRST_SYNC_RESET  = 8'hBB;
	localparam logic [7:0] SECOND_SYNC_RESET = 8'h66;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC2,
		ST_PAYLOAD,
		ST_CRC,
		ST_CHECK,
		ST_READ,
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       clear;
		logic       start;
		logic [7:0] data;
	} crc_ctl_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] crc;
	} crc_sts_t;

	// One MSB-first shift of the CRC register.
	function automatic logic [7:0] crc_step(input logic [7:0] c);
		logic [7:0] r;
		r = {c[6:0], 1'b0};
		if (c[7]) begin
			r = r ^ CRC_POLY;
		end
		return r;
	endfunction

endpackage

### hw/rtl/sync_framed_crc8_word_receiver_unit.sv
// Top level of the two-byte sync framed receiver with CRC-8 check.
`timescale 1ns / 1ps

// Receives serial bytes, hunts for the two sync bytes set in the configuration
// registers, stores PAYLOAD_BYTES payload bytes and checks them against the
// CRC-8 byte that follows (poly 0x07, init 0x00, MSB first). A good frame
// comes out as PAYLOAD_BYTES/4 little-endian words with last_word on the
// final one; a bad frame is dropped with no output. For each payload byte
// the bit-serial CRC unit does one polynomial step per cycle and in_stall
// stays high until it is done. After a good check byte each word is made
// by four byte reads from the single read port of the payload store, the
// output register load and the offer of the word, which is held for as long
// as out_stall holds it; no input is taken until the last word is gone. The
// store needs no clearing pass after reset.

module sync_framed_crc8_word_receiver_unit #(
	parameter int unsigned PAYLOAD_BYTES = 52
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfcrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [3:0]                       word_index,
	output logic [31:0]                      payload_word,
	output logic                             last_word
);
	import sfcrc_pkg::*;

	localparam int unsigned AW    = $clog2(PAYLOAD_BYTES);
	localparam int unsigned WORDS = PAYLOAD_BYTES / 4;
	localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PAYLOAD_BYTES - 1);
	localparam logic [WW-1:0] LAST_WORD = WW'(WORDS - 1);

	state_t        state_q, state_d;
	logic [7:0]    first_q, second_q;
	logic [AW-1:0] count_q;
	logic [AW-1:0] rd_addr_q;
	logic [1:0]    sel_q;
	logic [WW-1:0] word_q;
	logic          rd_pend_q;
	logic          out_valid_q;
	logic [31:0]   asm_q;
	logic [31:0]   payload_word_q;
	logic [3:0]    word_index_q;
	logic          last_word_q;

	crc_ctl_t   crc_ctl;
	crc_sts_t   crc_sts;
	logic       out_acc;
	logic       mem_we;
	logic       mem_re;
	logic [7:0] mem_rdata;
	logic       count_inc;
	logic       rd_start;
	logic       load_out;
	logic       next_word;
	logic       restart;
	logic [31:0]   word_full;
	logic [WW+3:0] word_wide;

	assign out_acc = out_valid_q && !out_stall;

	sfcrc_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.sts    (crc_sts)
	);

	sfcrc_store #(
		.DEPTH (PAYLOAD_BYTES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q),
		.wdata (rx_byte),
		.re    (mem_re),
		.raddr (rd_addr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		crc_ctl      = '0;
		crc_ctl.data = rx_byte;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		count_inc    = 1'b0;
		rd_start     = 1'b0;
		load_out     = 1'b0;
		next_word    = 1'b0;
		restart      = 1'b0;
		case (state_q)
			ST_HUNT: begin
				in_stall = 1'b0;
				if (in_valid && (rx_byte == first_q)) begin
					state_d = ST_SYNC2;
				end
			end
			ST_SYNC2: begin
				in_stall = 1'b0;
				if (in_valid) begin
					// a wrong second byte is consumed, not rechecked as a first
					restart = 1'b1;
					if (rx_byte == second_q) begin
						state_d = ST_PAYLOAD;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_PAYLOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					mem_we        = 1'b1;
					crc_ctl.start = 1'b1;
					state_d       = ST_CRC;
				end
			end
			ST_CRC: begin
				if (crc_sts.done) begin
					count_inc = 1'b1;
					if (count_q == LAST_ADDR) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_PAYLOAD;
					end
				end
			end
			ST_CHECK: begin
				in_stall = 1'b0;
				if (in_valid) begin
					restart = 1'b1;
					if (rx_byte == crc_sts.crc) begin
						rd_start = 1'b1;
						state_d  = ST_READ;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_READ: begin
				mem_re = 1'b1;
				if (sel_q == 2'd3) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				load_out = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc) begin
					next_word = 1'b1;
					if (word_q == LAST_WORD) begin
						state_d = ST_HUNT;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
		crc_ctl.clear = restart;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= FIRST_SYNC_RESET;
			second_q    <= SECOND_SYNC_RESET;
			count_q     <= '0;
			rd_addr_q   <= '0;
			sel_q       <= '0;
			word_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_SYNC:  first_q  <= cfg_data;
					REG_SECOND_SYNC: second_q <= cfg_data;
					default: ;
				endcase
			end
			if (restart) begin
				count_q <= '0;
			end else if (count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (rd_start) begin
				rd_addr_q <= '0;
				sel_q     <= '0;
				word_q    <= '0;
			end else begin
				if (mem_re) begin
					rd_addr_q <= rd_addr_q + 1'b1;
					sel_q     <= sel_q + 2'd1;
				end
				if (next_word) begin
					word_q <= word_q + 1'b1;
				end
			end
			rd_pend_q <= mem_re;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bytes arrive lowest first: shift in from the top
	assign word_full = {mem_rdata, asm_q[31:8]};
	assign word_wide = {4'b0, word_q};

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			asm_q <= word_full;
		end
		if (load_out) begin
			payload_word_q <= word_full;
			word_index_q   <= word_wide[3:0];
			last_word_q    <= (word_q == LAST_WORD);
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_word = payload_word_q;
	assign word_index   = word_index_q;
	assign last_word    = last_word_q;

endmodule

### hw/rtl/sfcrc_crc_unit.sv
// Bit-serial CRC-8 unit: one polynomial step per cycle, eight steps per byte.
`timescale 1ns / 1ps

module sfcrc_crc_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  sfcrc_pkg::crc_ctl_t ctl,
	output sfcrc_pkg::crc_sts_t sts
);
	import sfcrc_pkg::*;

	logic [7:0] crc_q;
	logic [2:0] bit_q;
	logic       busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.clear) begin
			crc_q  <= CRC_INIT;
			bit_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			// fold in the byte and take the first step at once
			crc_q  <= crc_step(crc_q ^ ctl.data);
			bit_q  <= 3'd1;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= crc_step(crc_q);
			bit_q <= bit_q + 3'd1;
			if (bit_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (bit_q == 3'd7);
	assign sts.crc  = crc_q;

endmodule

### hw/rtl/sfcrc_store.sv
// Payload byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module sfcrc_store #(
	parameter int unsigned DEPTH = 52,
	parameter int unsigned AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sim/crc8_frame_checker.sv
// Checker for the framed CRC-8 receiver: predicts the payload words and compares the output channel.
`timescale 1ns / 1ps

module crc8_frame_checker #(
	parameter int unsigned PAYLOAD_BYTES = 52
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfcrc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [7:0]                       rx_byte,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [3:0]                       word_index,
	input  logic [31:0]                      payload_word,
	input  logic                             last_word,
	output int unsigned                      mismatches,
	output int unsigned                      pending,
	output int unsigned                      words_checked
);

	import sfcrc_pkg::*;

	localparam int unsigned WORDS = PAYLOAD_BYTES / 4;

	typedef enum logic [1:0] {
		SEEK_FIRST,
		SEEK_SECOND,
		COLLECT,
		VERIFY
	} rx_phase_t;

	typedef struct packed {
		logic [3:0]  index;
		logic [31:0] data;
		logic        last;
	} frame_word_t;

	rx_phase_t   rx_phase;
	int unsigned byte_count;
	logic [7:0]  crc_acc;
	logic [7:0]  frame_bytes [PAYLOAD_BYTES];
	logic [7:0]  sync_first;
	logic [7:0]  sync_second;
	frame_word_t expected_words [$];
	int unsigned err_count;
	int unsigned word_count;

	// Bit at a time, MSB first: feedback is the top CRC bit xor the data bit.
	function automatic logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ d[i];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic take_rx_byte(input logic [7:0] b);
		frame_word_t w;
		case (rx_phase)
			SEEK_FIRST: begin
				if (b == sync_first) begin
					rx_phase = SEEK_SECOND;
				end
			end
			SEEK_SECOND: begin
				// a wrong second byte is consumed, never retried as a first sync
				rx_phase = (b == sync_second) ? COLLECT : SEEK_FIRST;
				byte_count = 0;
				crc_acc = CRC_INIT;
			end
			COLLECT: begin
				frame_bytes[byte_count] = b;
				crc_acc = fold_crc(crc_acc, b);
				byte_count++;
				if (byte_count == PAYLOAD_BYTES) begin
					rx_phase = VERIFY;
				end
			end
			default: begin
				if (b == crc_acc) begin
					for (int k = 0; k < WORDS; k++) begin
						w.index = 4'(k);
						w.data = {frame_bytes[4*k+3], frame_bytes[4*k+2],
							frame_bytes[4*k+1], frame_bytes[4*k]};
						w.last = (k == WORDS - 1);
						expected_words.push_back(w);
					end
				end
				rx_phase = SEEK_FIRST;
				byte_count = 0;
				crc_acc = CRC_INIT;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_word_t want;
		if (!arst_n) begin
			rx_phase = SEEK_FIRST;
			byte_count = 0;
			crc_acc = CRC_INIT;
			sync_first = FIRST_SYNC_RESET;
			sync_second = SECOND_SYNC_RESET;
			expected_words.delete();
			err_count = 0;
			word_count = 0;
		end else begin
			// results first: a word can never leave at the edge that takes its cause
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					if (err_count < 10) begin
						$display("%0t: unexpected word idx=%0d data=%08h last=%0b",
							$realtime, word_index, payload_word, last_word);
					end
					err_count++;
				end else begin
					want = expected_words.pop_front();
					if (want !== {word_index, payload_word, last_word}) begin
						if (err_count < 10) begin
							$write("%0t: word mismatch exp idx=%0d data=%08h last=%0b, ",
								$realtime, want.index, want.data, want.last);
							$display("got idx=%0d data=%08h last=%0b",
								word_index, payload_word, last_word);
						end
						err_count++;
					end
				end
				word_count++;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_SYNC: begin
						sync_first = cfg_data;
					end
					REG_SECOND_SYNC: begin
						sync_second = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				take_rx_byte(rx_byte);
			end
		end
		mismatches <= err_count;
		pending <= expected_words.size();
		words_checked <= word_count;
	end

endmodule

### sim/testbench.sv
// Bench top for the framed CRC-8 receiver: clock, reset, byte and sync stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

	import sfcrc_pkg::*;

	localparam int unsigned PAYLOAD_BYTES = 52;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned QUIET_CYCLES = 20;
	localparam int unsigned PHASE_BYTES = 40;

	typedef enum {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_BAD_SECOND,
		FRAME_DOUBLE_FIRST
	} frame_kind_t;

	typedef enum {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_RAMP
	} fill_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            rx_byte;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [3:0]            word_index;
	logic [31:0]           payload_word;
	logic                  last_word;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned words_checked;

	int unsigned cycle_count = 0;
	int unsigned stall_hold = 0;
	int unsigned stall_roll;
	bit          no_gaps = 1'b0;
	logic [7:0]  first_sync;
	logic [7:0]  second_sync;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned settings_used = 1;

	always #5 clk = ~clk;

	sync_framed_crc8_word_receiver_unit #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_index(word_index),
		.payload_word(payload_word),
		.last_word(last_word)
	);

	crc8_frame_checker #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) frame_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_index(word_index),
		.payload_word(payload_word),
		.last_word(last_word),
		.mismatches(mismatches),
		.pending(pending),
		.words_checked(words_checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d words still pending",
				cycle_count, pending);
			$display("FAIL");
			$finish;
		end
	end

	// Output back-pressure: mostly short random runs with or without stall, now and then a long stall or a quiet stretch.
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 8) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(50, 200);
			end else if (stall_roll < 55) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 3);
			end else if (stall_roll < 95) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	function automatic logic [7:0] crc8_shift_in(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] c;
		c = acc ^ d;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Hold the request until taken; keep valid up when the next one follows at once.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Line noise that never holds the first sync byte.
	task automatic send_noise(input int unsigned n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == first_sync) begin
				b = b ^ 8'h01;
			end
			send_byte(b);
		end
	endtask

	task automatic send_frame(input frame_kind_t kind, input fill_t fill);
		logic [7:0] crc;
		logic [7:0] b;
		frames_sent++;
		if (kind == FRAME_BAD_SECOND) begin
			send_byte(first_sync);
			if (first_sync != second_sync && $urandom_range(0, 1) == 1) begin
				b = first_sync;
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == second_sync) begin
					b = ~b;
				end
			end
			send_byte(b);
			return;
		end
		if (kind == FRAME_DOUBLE_FIRST) begin
			send_byte(first_sync);
		end
		send_byte(first_sync);
		send_byte(second_sync);
		crc = CRC_INIT;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			case (fill)
				FILL_ZERO: begin
					b = 8'h00;
				end
				FILL_ONES: begin
					b = 8'hFF;
				end
				FILL_RAMP: begin
					b = 8'(i * 5 + 1);
				end
				default: begin
					b = 8'($urandom_range(0, 255));
				end
			endcase
			crc = crc8_shift_in(crc, b);
			send_byte(b);
		end
		if (kind == FRAME_BAD_CRC) begin
			crc = crc ^ (8'h01 << $urandom_range(0, 7));
		end
		send_byte(crc);
	endtask

	// Drop valid, drain the expected words, then let the block finish any byte in progress.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_sync(input logic [7:0] a, input logic [7:0] b);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIRST_SYNC;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= REG_SECOND_SYNC;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		first_sync = a;
		second_sync = b;
		settings_used++;
	endtask

	task automatic run_random(input int unsigned target);
		int unsigned start;
		int unsigned good;
		int unsigned r;
		fill_t       fill;
		start = bytes_sent;
		good = 0;
		while (bytes_sent - start < target || good == 0) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) begin
				send_noise($urandom_range(1, 6));
			end
			r = $urandom_range(0, 99);
			fill = (r % 10 == 0) ? FILL_ZERO : (r % 10 == 1) ? FILL_ONES : FILL_RANDOM;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(FRAME_GOOD, fill);
				good++;
			end else if (r < 82) begin
				send_frame(FRAME_BAD_CRC, fill);
			end else if (r < 91) begin
				send_frame(FRAME_BAD_SECOND, fill);
			end else begin
				send_frame(FRAME_DOUBLE_FIRST, fill);
				good++;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FIRST_SYNC;
		cfg_data <= '0;
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		first_sync = FIRST_SYNC_RESET;
		second_sync = SECOND_SYNC_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset sync pair
		send_frame(FRAME_GOOD, FILL_ZERO);
		send_frame(FRAME_BAD_CRC, FILL_RAMP);
		send_frame(FRAME_BAD_SECOND, FILL_RANDOM);
		send_frame(FRAME_DOUBLE_FIRST, FILL_ONES);
		send_byte(second_sync);
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();

		set_sync(8'h00, 8'hFF);
		run_random(PHASE_BYTES);
		settle();
		set_sync(8'hFF, 8'h00);
		run_random(PHASE_BYTES);
		settle();
		first_sync = 8'($urandom_range(0, 255));
		set_sync(first_sync, first_sync);
		run_random(PHASE_BYTES);
		settle();
		set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_random(PHASE_BYTES);
		settle();

		$display("Sent %0d bytes in %0d frames under %0d sync settings.",
			bytes_sent, frames_sent, settings_used);
		$display("Compared %0d payload words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
